// File: sv/ship_pkg.sv
`timescale 1ns / 1ps

package ship_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ship_state_e;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } ship_op_e;

  localparam logic [1:0] RRPV_MAX      = 2'd3;
  localparam logic [1:0] RRPV_MID      = 2'd2;
  localparam logic [1:0] RRPV_NEAR     = 2'd0;
  localparam logic [1:0] CNT_MAX       = 2'd3;
  localparam logic [1:0] REUSE_RESET   = 2'd1;
  localparam logic [1:0] THRESH_RESET  = 2'd3;
  localparam int unsigned STRIDE_ONE   = 64;
  localparam int unsigned STRIDE_TWO   = 128;

  // control bundle from the sequencer to the datapath
  typedef struct packed {
    logic busy;
    logic clr_en;
    logic exec_en;
  } ship_ctrl_t;

  // reciprocal of a constant modulus, scaled by 2^22 and rounded up
  function automatic logic [22:0] ship_rcp(input int unsigned m);
    return 23'(((64'd1 << 22) + 64'(m) - 64'd1) / 64'(m));
  endfunction

  // remainder of an 11-bit index by a constant modulus, by reciprocal multiply
  function automatic logic [10:0] ship_mod(input logic [10:0] v, input int unsigned m,
                                           input logic [22:0] rcp);
    logic [33:0] prod;
    logic [10:0] quo;
    logic [21:0] back;
    prod = 34'(v) * 34'(rcp);
    quo  = prod[32:22];
    back = 22'(quo) * 22'(m);
    if (m >= 32'd2048) begin
      return v;
    end
    return v - back[10:0];
  endfunction

endpackage

// File: sv/ship_rrip_stream_bypass_replacement.sv
`timescale 1ns / 1ps

// Replacement policy engine: victim choice and post-access update for a set-associative
// cache with 2-bit RRPVs, a per-set stream detector and per-signature reuse counters.
// An item is accepted when start is high and busy is low. On acceptance the block does
// the synchronous read of the set entry (RRPV row, stream counter, previous address)
// and the reuse counter; in the execute state, with busy high, it modifies and writes
// them back. Its result shows on the result ports with strobe_o for exactly one cycle,
// the cycle after the write-back, while the next item may already be accepted; the
// receiver cannot stall, so results must be captured on the strobe. After reset the
// block runs a clearing pass over every entry of both memories with busy high; threshold
// writes are taken at any time but are meant for idle periods.
module ship_rrip_stream_bypass_replacement #(
  parameter int unsigned NUM_SETS    = 2048,
  parameter int unsigned NUM_WAYS    = 16,
  parameter int unsigned SIG_ENTRIES = 2048,
  parameter int unsigned ADDR_BITS   = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_index_i,
  input  logic [47:0] phys_address_i,
  input  logic [10:0] signature_i,
  input  logic        hit_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  output logic        strobe_o,
  output logic [3:0]  victim_way_o,
  output logic        streaming_o,
  output logic [1:0]  new_rrpv_o
);
  import ship_pkg::*;

  localparam int unsigned SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SIG_W     = $clog2(SIG_ENTRIES);
  localparam int unsigned WAY_W     = $clog2(NUM_WAYS);
  localparam int unsigned AW        = (ADDR_BITS < 48) ? ADDR_BITS : 48;
  localparam int unsigned DW        = AW + 1;
  localparam int unsigned CLR_DEPTH = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH + 1);

  localparam logic [22:0] SET_RCP = ship_rcp(NUM_SETS);
  localparam logic [22:0] WAY_RCP = ship_rcp(NUM_WAYS);
  localparam logic [22:0] SIG_RCP = ship_rcp(SIG_ENTRIES);

  // deltas are one bit wider than the address so both signs stay exact
  localparam logic [DW-1:0] D_P64  = DW'(STRIDE_ONE);
  localparam logic [DW-1:0] D_P128 = DW'(STRIDE_TWO);
  localparam logic [DW-1:0] D_N64  = DW'(0) - DW'(STRIDE_ONE);
  localparam logic [DW-1:0] D_N128 = DW'(0) - DW'(STRIDE_TWO);

  typedef struct packed {
    logic [1:0]                strm;
    logic [AW-1:0]             prev;
    logic [NUM_WAYS-1:0][1:0]  rrpv;
  } set_entry_t;

  set_entry_t  set_mem [NUM_SETS];
  logic [1:0]  sig_mem [SIG_ENTRIES];

  ship_state_e state_q, state_d;
  ship_ctrl_t  ctrl;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic [1:0]  thr_q;
  logic        accept;

  // item registers
  logic             op_q;
  logic [SET_W-1:0] set_q;
  logic [WAY_W-1:0] way_q;
  logic [AW-1:0]    addr_q;
  logic [SIG_W-1:0] sig_q;
  logic             hit_q;

  logic [SET_W-1:0] set_idx;
  logic [WAY_W-1:0] way_idx;
  logic [SIG_W-1:0] sig_idx;

  set_entry_t set_rd_q;
  logic [1:0] sig_rd_q;

  // datapath results
  set_entry_t       set_wr;
  logic [1:0]       cnt_new;
  logic             sig_we;
  logic [1:0]       top;
  logic [WAY_W-1:0] best;
  logic             found;
  logic [DW-1:0]    diff;
  logic             match;
  logic [1:0]       strm_new;
  logic             strm_hit;
  logic [1:0]       nr;

  assign accept  = start && !busy;
  assign busy    = ctrl.busy;
  assign set_idx = SET_W'(ship_mod(set_index_i, NUM_SETS, SET_RCP));
  assign way_idx = WAY_W'(ship_mod(11'(way_index_i), NUM_WAYS, WAY_RCP));
  assign sig_idx = SIG_W'(ship_mod(signature_i, SIG_ENTRIES, SIG_RCP));

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CLR_W'(1);
        if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_CLEAR: begin
        ctrl.busy   = 1'b1;
        ctrl.clr_en = 1'b1;
      end
      ST_IDLE: ctrl = '0;
      ST_EXEC: begin
        ctrl.busy    = 1'b1;
        ctrl.exec_en = 1'b1;
      end
      default: ctrl.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      thr_q   <= THRESH_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      set_q  <= set_idx;
      way_q  <= way_idx;
      addr_q <= phys_address_i[AW-1:0];
      sig_q  <= sig_idx;
      hit_q  <= hit_i;
    end
  end

  // stream detector and insertion policy
  always_comb begin
    diff  = {1'b0, addr_q} - {1'b0, set_rd_q.prev};
    match = (set_rd_q.prev != '0) &&
            (diff == D_P64 || diff == D_P128 || diff == D_N64 || diff == D_N128);
    if (match) begin
      strm_new = (set_rd_q.strm == CNT_MAX) ? CNT_MAX : set_rd_q.strm + 2'd1;
    end else begin
      strm_new = (set_rd_q.strm == 2'd0) ? 2'd0 : set_rd_q.strm - 2'd1;
    end
    strm_hit = (strm_new >= thr_q);

    cnt_new = sig_rd_q;
    if (hit_q) begin
      nr = RRPV_NEAR;
      if (sig_rd_q != CNT_MAX) begin
        cnt_new = sig_rd_q + 2'd1;
      end
    end else if (strm_hit) begin
      nr = RRPV_MAX;
      if (sig_rd_q != 2'd0) begin
        cnt_new = sig_rd_q - 2'd1;
      end
    end else begin
      if (sig_rd_q >= 2'd2) begin
        nr = RRPV_NEAR;
      end else if (sig_rd_q == 2'd1) begin
        nr = RRPV_MID;
      end else begin
        nr = RRPV_MAX;
      end
    end
  end

  // victim search: max of the row, then the lowest way holding it
  always_comb begin
    top[1] = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      top[1] = top[1] | set_rd_q.rrpv[w][1];
    end
    top[0] = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      top[0] = top[0] | (set_rd_q.rrpv[w][0] && (set_rd_q.rrpv[w][1] == top[1]));
    end
    best  = '0;
    found = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && set_rd_q.rrpv[w] == top) begin
        best  = WAY_W'(w);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    set_wr = set_rd_q;
    sig_we = 1'b0;
    if (op_q == OP_VICTIM) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        set_wr.rrpv[w] = set_rd_q.rrpv[w] + (RRPV_MAX - top);
      end
    end else begin
      set_wr.rrpv[way_q] = nr;
      set_wr.strm        = strm_new;
      set_wr.prev        = addr_q;
      sig_we             = 1'b1;
    end
  end

  // set memory: clearing pass, read on accept, write back in the execute state
  always_ff @(posedge clk_i) begin
    if (ctrl.clr_en && clr_q < CLR_W'(NUM_SETS)) begin
      set_mem[clr_q[SET_W-1:0]] <= '{strm: 2'd0, prev: '0, rrpv: {NUM_WAYS{RRPV_MAX}}};
    end else if (ctrl.exec_en) begin
      set_mem[set_q] <= set_wr;
    end
    if (accept) begin
      set_rd_q <= set_mem[set_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clr_en && clr_q < CLR_W'(SIG_ENTRIES)) begin
      sig_mem[clr_q[SIG_W-1:0]] <= REUSE_RESET;
    end else if (ctrl.exec_en && sig_we) begin
      sig_mem[sig_q] <= cnt_new;
    end
    if (accept) begin
      sig_rd_q <= sig_mem[sig_idx];
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= ctrl.exec_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.exec_en) begin
      if (op_q == OP_VICTIM) begin
        victim_way_o <= 4'(best);
        streaming_o  <= 1'b0;
        new_rrpv_o   <= 2'd0;
      end else begin
        victim_way_o <= 4'd0;
        streaming_o  <= strm_hit;
        new_rrpv_o   <= nr;
      end
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted item did not enter the execute cycle");

  a_strobe_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ($past(state_q) == ST_EXEC))
    else $error("result strobe without an executed item");

  a_victim_zero_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (streaming_o || new_rrpv_o != 2'd0)) |-> (victim_way_o == 4'd0))
    else $error("update result carries a victim way");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !accept)
    else $error("item accepted during clearing pass");

endmodule

// File: tb/sv/tb_ship_rrip_stream_bypass_replacement.sv
`timescale 1ns / 1ps

module tb_ship_rrip_stream_bypass_replacement;
  import ship_pkg::*;

  localparam int unsigned NSETS     = 2048;
  localparam int unsigned NWAYS     = 16;
  localparam int unsigned NSIGS     = 2048;
  localparam int unsigned QUIET_MAX = 6000;
  localparam int unsigned PHASE_LEN = 200;

  typedef struct {
    ship_op_e    op;
    logic [10:0] set_idx;
    logic [3:0]  way;
    logic [47:0] addr;
    logic [10:0] sig;
    logic        hit;
  } access_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       streaming;
    logic [1:0] new_rrpv;
  } outcome_t;

  class replacement_scoreboard;
    logic [1:0]  rrpv_q [NSETS][NWAYS];
    logic [1:0]  reuse_q [NSIGS];
    logic [1:0]  stride_cnt_q [NSETS];
    logic [47:0] last_addr_q [NSETS];
    logic [1:0]  threshold_q;
    outcome_t    expected_outcomes [$];
    int          mismatch_count;

    function new();
      for (int s = 0; s < NSETS; s++) begin
        for (int w = 0; w < NWAYS; w++) rrpv_q[s][w] = RRPV_MAX;
        stride_cnt_q[s] = '0;
        last_addr_q[s]  = '0;
      end
      for (int g = 0; g < NSIGS; g++) reuse_q[g] = REUSE_RESET;
      threshold_q    = THRESH_RESET;
      mismatch_count = 0;
    endfunction

    function void set_threshold(logic [1:0] thr);
      threshold_q = thr;
    endfunction

    function int outstanding();
      return expected_outcomes.size();
    endfunction

    function outcome_t predict_access(access_t a);
      outcome_t    r;
      logic [1:0]  top;
      logic [3:0]  pick;
      logic [47:0] prior;
      logic [47:0] delta;
      logic        near;
      r = '0;
      if (a.op == OP_VICTIM) begin
        top  = rrpv_q[a.set_idx][0];
        pick = '0;
        for (int w = 1; w < NWAYS; w++) begin
          if (rrpv_q[a.set_idx][w] > top) begin
            top  = rrpv_q[a.set_idx][w];
            pick = w[3:0];
          end
        end
        // age the whole row so the oldest lands on the max value
        for (int w = 0; w < NWAYS; w++)
          rrpv_q[a.set_idx][w] = rrpv_q[a.set_idx][w] + (RRPV_MAX - top);
        r.victim_way = pick;
      end else begin
        prior = last_addr_q[a.set_idx];
        delta = (a.addr > prior) ? a.addr - prior : prior - a.addr;
        // a zero previous address means the set has no history
        near  = (prior != '0) && (delta == 48'(STRIDE_ONE) || delta == 48'(STRIDE_TWO));
        if (near) begin
          if (stride_cnt_q[a.set_idx] != CNT_MAX) stride_cnt_q[a.set_idx]++;
        end else if (stride_cnt_q[a.set_idx] != '0) begin
          stride_cnt_q[a.set_idx]--;
        end
        last_addr_q[a.set_idx] = a.addr;
        r.streaming = (stride_cnt_q[a.set_idx] >= threshold_q);
        if (a.hit) begin
          r.new_rrpv = RRPV_NEAR;
          if (reuse_q[a.sig] != CNT_MAX) reuse_q[a.sig]++;
        end else if (r.streaming) begin
          r.new_rrpv = RRPV_MAX;
          if (reuse_q[a.sig] != '0) reuse_q[a.sig]--;
        end else if (reuse_q[a.sig] >= 2'd2) begin
          r.new_rrpv = RRPV_NEAR;
        end else if (reuse_q[a.sig] == 2'd1) begin
          r.new_rrpv = RRPV_MID;
        end else begin
          r.new_rrpv = RRPV_MAX;
        end
        rrpv_q[a.set_idx][a.way] = r.new_rrpv;
      end
      return r;
    endfunction

    function void note_access(access_t a);
      expected_outcomes.push_back(predict_access(a));
    endfunction

    function void check_result(logic [3:0] vw, logic st, logic [1:0] nr);
      outcome_t e;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result victim_way %0d streaming %0d new_rrpv %0d",
                 $time, vw, st, nr);
        mismatch_count++;
        return;
      end
      e = expected_outcomes.pop_front();
      if (vw !== e.victim_way) begin
        $display("%0t: victim_way expected %0d actual %0d", $time, e.victim_way, vw);
        mismatch_count++;
      end
      if (st !== e.streaming) begin
        $display("%0t: streaming expected %0d actual %0d", $time, e.streaming, st);
        mismatch_count++;
      end
      if (nr !== e.new_rrpv) begin
        $display("%0t: new_rrpv expected %0d actual %0d", $time, e.new_rrpv, nr);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        operation_i;
  logic [10:0] set_index_i;
  logic [3:0]  way_index_i;
  logic [47:0] phys_address_i;
  logic [10:0] signature_i;
  logic        hit_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        strobe_o;
  logic [3:0]  victim_way_o;
  logic        streaming_o;
  logic [1:0]  new_rrpv_o;

  replacement_scoreboard tracker;
  access_t     seen;
  int unsigned quiet_cycles;
  int unsigned items_sent;
  int unsigned idle_pct;
  logic [10:0] hot_sets [3];
  logic [10:0] hot_sigs [3];
  logic [1:0]  phase_thr [7] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2};

  ship_rrip_stream_bypass_replacement uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .set_index_i    (set_index_i),
    .way_index_i    (way_index_i),
    .phys_address_i (phys_address_i),
    .signature_i    (signature_i),
    .hit_i          (hit_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .strobe_o       (strobe_o),
    .victim_way_o   (victim_way_o),
    .streaming_o    (streaming_o),
    .new_rrpv_o     (new_rrpv_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // sample everything at the rising edge; config writes go straight into the model
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o) tracker.check_result(victim_way_o, streaming_o, new_rrpv_o);
      if (cfg_we_i) tracker.set_threshold(cfg_wdata_i);
      if (start && !busy) begin
        seen.op      = ship_op_e'(operation_i);
        seen.set_idx = set_index_i;
        seen.way     = way_index_i;
        seen.addr    = phys_address_i;
        seen.sig     = signature_i;
        seen.hit     = hit_i;
        tracker.note_access(seen);
      end
      if (strobe_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic drive_item(input access_t a);
    int unsigned gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start          <= 1'b1;
    operation_i    <= a.op;
    set_index_i    <= a.set_idx;
    way_index_i    <= a.way;
    phys_address_i <= a.addr;
    signature_i    <= a.sig;
    hit_i          <= a.hit;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic send_update(input logic [10:0] s, input logic [3:0] w,
                             input logic [47:0] addr, input logic [10:0] g, input logic h);
    access_t a;
    a.op = OP_UPDATE; a.set_idx = s; a.way = w; a.addr = addr; a.sig = g; a.hit = h;
    drive_item(a);
  endtask

  task automatic send_victim(input logic [10:0] s);
    access_t     a;
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    // unused fields carry junk on victim requests
    a.op = OP_VICTIM; a.set_idx = s; a.way = 4'($urandom); a.addr = wide[47:0];
    a.sig = 11'($urandom); a.hit = 1'($urandom);
    drive_item(a);
  endtask

  task automatic quiesce_and_set_threshold(input logic [1:0] thr);
    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [10:0] pick_set();
    if ($urandom_range(0, 99) < 85) return hot_sets[$urandom_range(0, 2)];
    return 11'($urandom);
  endfunction

  function automatic logic [10:0] pick_sig();
    if ($urandom_range(0, 99) < 80) return hot_sigs[$urandom_range(0, 2)];
    return 11'($urandom);
  endfunction

  function automatic logic [47:0] rand_addr();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[47:0];
  endfunction

  // strided run over one set, with occasional stride changes and breaks
  task automatic stream_run();
    logic [10:0] s;
    logic [47:0] addr;
    int unsigned step;
    int unsigned len;
    int unsigned roll;
    bit          down;
    s    = pick_set();
    addr = rand_addr();
    step = $urandom_range(0, 1) ? STRIDE_TWO : STRIDE_ONE;
    down = 1'($urandom);
    len  = $urandom_range(3, 10);
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) addr = down ? addr - 48'(step) : addr + 48'(step);
      else if (roll < 90) addr = addr + 48'($urandom_range(0, 1) ? STRIDE_ONE : STRIDE_TWO);
      else addr = addr + 48'($urandom_range(1, 300));
      if ($urandom_range(0, 99) < 5) send_victim(s);
      send_update(s, 4'($urandom), addr, pick_sig(), $urandom_range(0, 99) < 30);
    end
  endtask

  // touch every way of a row, then ask for victims so aging kicks in
  task automatic row_sweep();
    logic [10:0] s;
    logic [3:0]  first;
    s     = pick_set();
    first = 4'($urandom);
    for (int i = 0; i < NWAYS; i++)
      send_update(s, first + i[3:0], rand_addr(), pick_sig(), $urandom_range(0, 99) < 50);
    repeat ($urandom_range(1, 3)) send_victim(s);
  endtask

  task automatic noise_item();
    if ($urandom_range(0, 1)) send_victim(11'($urandom));
    else send_update(11'($urandom), 4'($urandom), rand_addr(), 11'($urandom), 1'($urandom));
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned target;
    int unsigned roll;
    target = items_sent + count;
    for (int i = 0; i < 3; i++) begin
      hot_sets[i] = 11'($urandom);
      hot_sigs[i] = 11'($urandom);
    end
    while (items_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) stream_run();
      else if (roll < 60) row_sweep();
      else if (roll < 75) repeat ($urandom_range(2, 4)) send_victim(pick_set());
      else noise_item();
    end
  endtask

  initial begin
    tracker        = new();
    quiet_cycles   = 0;
    items_sent     = 0;
    idle_pct       = 14;
    rst_ni         = 1'b0;
    start          = 1'b0;
    operation_i    = 1'b0;
    set_index_i    = '0;
    way_index_i    = '0;
    phys_address_i = '0;
    signature_i    = '0;
    hit_i          = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // wait out the clearing pass
    do @(posedge clk_i); while (busy);
    quiesce_and_set_threshold(THRESH_RESET);

    send_victim(11'd0);
    send_update(11'd0, 4'd15, 48'd0, 11'd0, 1'b1);
    // previous address zero counts as no history even with a 64 byte step
    send_update(11'd0, 4'd1, 48'd64, 11'd0, 1'b0);
    send_update(11'd0, 4'd2, 48'd128, 11'd1, 1'b0);
    send_update(11'd0, 4'd3, 48'd256, 11'd1, 1'b0);
    send_update(11'd0, 4'd4, 48'd192, 11'd1, 1'b0);
    send_update(11'd0, 4'd5, 48'd128, 11'd2047, 1'b0);
    send_update(11'd0, 4'd6, 48'd130, 11'd1, 1'b0);
    send_victim(11'd0);
    send_update(11'd2047, 4'd15, 48'hFFFF_FFFF_FFFF, 11'd2047, 1'b1);
    send_update(11'd2047, 4'd0, 48'hFFFF_FFFF_FFBF, 11'd5, 1'b1);
    send_update(11'd2047, 4'd8, 48'hFFFF_FFFF_FF3F, 11'd5, 1'b1);
    send_update(11'd2047, 4'd9, 48'h0000_0000_0001, 11'd5, 1'b0);
    send_victim(11'd2047);
    send_victim(11'd2047);

    for (int p = 0; p < 7; p++) begin
      quiesce_and_set_threshold(phase_thr[p]);
      idle_pct = (p == 3) ? 0 : 14;
      random_phase(PHASE_LEN);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
